[design/fdrs_pkg.sv]
// Package with register indexes, reset values and widths of the frame duty refresh scheduler.
`default_nettype none

package fdrs_pkg;

   localparam int FT_W = 17;

   typedef logic [1:0]      csr_index_type;
   typedef logic [FT_W-1:0] frame_time_type;

   localparam csr_index_type CSR_FRAME_PERIOD  = 2'd0;
   localparam csr_index_type CSR_DUTY_STEP     = 2'd1;
   localparam csr_index_type CSR_CLEAR_TIME    = 2'd2;
   localparam csr_index_type CSR_REFRESH_TIME  = 2'd3;

   localparam logic [15:0] FRAME_PERIOD_RESET = 16'd25641;
   localparam logic [9:0]  DUTY_STEP_RESET    = 10'd256;
   localparam logic [15:0] CLEAR_TIME_RESET   = 16'd5670;
   localparam logic [15:0] REFRESH_TIME_RESET = 16'd12116;

   localparam logic [7:0]  DUTY_MAX = 8'd100;

endpackage : fdrs_pkg

`default_nettype wire

[design/frame_duty_refresh_scheduler_unit.sv]
// Frame duty refresh scheduler: frame-time accumulator with refresh and clear pulse timing.
//
// Usage: each request carries a duty percentage and the microseconds elapsed
// since the previous request. The block answers every request with exactly one
// response holding frame_wrapped, refresh_now and clear_now.
// Both channels use valid and stall; a transfer happens at a clock edge with
// valid high and stall low. The csr_ port writes one register per cycle, and the user
// must use it only while the block is idle; the block itself does not enforce this.
// A request that does not wrap the frame passes S_WRAP and then S_EVAL, which
// loads the response register. A wrapping request passes S_DIV in between: the
// accumulator minus one is reduced modulo the frame period by a restoring
// divider that shares one 17-bit subtractor and retires one bit per cycle
// over the 17 dividend bits, and one is then added back. Requests are taken
// only while the sequencer is idle; the response register lets the next request
// be accepted while the previous response still waits.
// When the receiver stalls, the response holds and the sequencer waits at its
// final step until the response register is free.
// Synchronous reset clears the accumulator, the done flags and the response
// valid, and loads the register reset values.
`default_nettype none

module frame_duty_refresh_scheduler_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_duty_percent,
   input  wire logic [15:0]                req_elapsed_us,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_frame_wrapped,
   output logic                            rsp_refresh_now,
   output logic                            rsp_clear_now,
   input  wire logic                       csr_write_enable,
   input  wire fdrs_pkg::csr_index_type    csr_index,
   input  wire logic [15:0]                csr_write_data
);
   import fdrs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WRAP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EVAL = 2'd3;

   localparam int          CNT_W     = $clog2(FT_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FT_W - 1);

   // Configuration registers.
   logic [15:0] frame_period_ff, frame_period_in;
   logic [9:0]  duty_step_ff, duty_step_in;
   logic [15:0] clear_time_ff, clear_time_in;
   logic [15:0] refresh_time_ff, refresh_time_in;

   // Sequencer and datapath.
   logic [1:0]       state_ff, state_in;
   frame_time_type   frame_time_ff, frame_time_in;
   logic             refresh_done_ff, refresh_done_in;
   logic             clear_done_ff, clear_done_in;
   logic             wrapped_ff, wrapped_in;
   logic [6:0]       duty_ff, duty_in;
   logic [16:0]      product_ff, product_in;
   frame_time_type   dividend_ff, dividend_in;
   frame_time_type   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_wrapped_ff, rsp_wrapped_in;
   logic rsp_refresh_ff, rsp_refresh_in;
   logic rsp_clear_ff, rsp_clear_in;

   logic [15:0]    period;
   logic           req_accept;
   logic           rsp_free;
   frame_time_type rem_shift;
   logic [FT_W:0]  rem_diff;
   frame_time_type rem_next;
   logic [FT_W:0]  ft_plus_refresh;
   logic [FT_W:0]  ft_plus_clear;
   logic [FT_W:0]  ft_plus_both;
   logic           refresh_hit;
   logic           clear_hit;

   // A zero period behaves as a period of one.
   assign period = (frame_period_ff == 16'd0) ? 16'd1 : frame_period_ff;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Shared subtractor of the restoring divider.
   assign rem_shift = {rem_ff[FT_W-2:0], dividend_ff[FT_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, period};
   assign rem_next  = rem_diff[FT_W] ? rem_shift : rem_diff[FT_W-1:0];

   // Thresholds are compared with the subtrahends moved to the other side, so
   // every quantity stays non-negative.
   assign ft_plus_refresh = {1'b0, frame_time_ff} + {2'b00, refresh_time_ff};
   assign ft_plus_clear   = {1'b0, frame_time_ff} + {2'b00, clear_time_ff};
   assign ft_plus_both    = ft_plus_clear + {2'b00, refresh_time_ff};

   assign refresh_hit = (ft_plus_refresh >= {2'b00, period}) && !refresh_done_ff;
   // The duty time raised to the clear time needs no separate maximum: when the
   // product is below the clear time the lower bound holds for any frame time.
   assign clear_hit   = (ft_plus_clear >= {1'b0, product_ff})
                        && ({2'b00, period} > ft_plus_both) && !clear_done_ff;

   always_comb begin
      frame_period_in = frame_period_ff;
      duty_step_in    = duty_step_ff;
      clear_time_in   = clear_time_ff;
      refresh_time_in = refresh_time_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_PERIOD: begin
               frame_period_in = csr_write_data;
            end
            CSR_DUTY_STEP: begin
               duty_step_in = csr_write_data[9:0];
            end
            CSR_CLEAR_TIME: begin
               clear_time_in = csr_write_data;
            end
            CSR_REFRESH_TIME: begin
               refresh_time_in = csr_write_data;
            end
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      frame_time_in   = frame_time_ff;
      refresh_done_in = refresh_done_ff;
      clear_done_in   = clear_done_ff;
      wrapped_in      = wrapped_ff;
      duty_in         = duty_ff;
      product_in      = product_ff;
      dividend_in     = dividend_ff;
      rem_in          = rem_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_wrapped_in  = rsp_wrapped_ff;
      rsp_refresh_in  = rsp_refresh_ff;
      rsp_clear_in    = rsp_clear_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               frame_time_in = frame_time_ff + {1'b0, req_elapsed_us};
               duty_in       = (req_duty_percent > DUTY_MAX) ? DUTY_MAX[6:0]
                                                             : req_duty_percent[6:0];
               state_in      = S_WRAP;
            end
         end
         S_WRAP: begin
            product_in = 17'(duty_ff * duty_step_ff);
            if (frame_time_ff > {1'b0, period}) begin
               wrapped_in      = 1'b1;
               refresh_done_in = 1'b0;
               clear_done_in   = 1'b0;
               dividend_in     = frame_time_ff - frame_time_type'(1);
               rem_in          = '0;
               cnt_in          = '0;
               state_in        = S_DIV;
            end else begin
               wrapped_in = 1'b0;
               state_in   = S_EVAL;
            end
         end
         S_DIV: begin
            rem_in      = rem_next;
            dividend_in = {dividend_ff[FT_W-2:0], 1'b0};
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               frame_time_in = rem_next + frame_time_type'(1);
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_wrapped_in = wrapped_ff;
               rsp_refresh_in = refresh_hit;
               rsp_clear_in   = clear_hit;
               if (refresh_hit) begin
                  refresh_done_in = 1'b1;
               end
               if (clear_hit) begin
                  clear_done_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff <= FRAME_PERIOD_RESET;
         duty_step_ff    <= DUTY_STEP_RESET;
         clear_time_ff   <= CLEAR_TIME_RESET;
         refresh_time_ff <= REFRESH_TIME_RESET;
         state_ff        <= S_IDLE;
         frame_time_ff   <= '0;
         refresh_done_ff <= 1'b0;
         clear_done_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_period_ff <= frame_period_in;
         duty_step_ff    <= duty_step_in;
         clear_time_ff   <= clear_time_in;
         refresh_time_ff <= refresh_time_in;
         state_ff        <= state_in;
         frame_time_ff   <= frame_time_in;
         refresh_done_ff <= refresh_done_in;
         clear_done_ff   <= clear_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wrapped_ff     <= wrapped_in;
      duty_ff        <= duty_in;
      product_ff     <= product_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
      rsp_refresh_ff <= rsp_refresh_in;
      rsp_clear_ff   <= rsp_clear_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_wrapped = rsp_wrapped_ff;
   assign rsp_refresh_now   = rsp_refresh_ff;
   assign rsp_clear_now     = rsp_clear_ff;

endmodule : frame_duty_refresh_scheduler_unit

`default_nettype wire
